// ===== rtl/wlt_pkg.sv =====
// ----------------------------------------------------------------------------
// wlt_pkg: shared types and constants for the worker lease table
// Entry count, field widths, command and result codes, entry and sequencer states
// and the structs that pass between the control logic and the row of table cells.
// ----------------------------------------------------------------------------
package wlt_pkg;

    // Table geometry
    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int AGE_W  = 6;
    localparam int ADDR_W = 8;
    localparam int CNT_W  = 4;
    localparam int SLOT_W = 3;

    localparam logic [AGE_W-1:0] AGE_MAX         = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(6);
    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

    // Command kinds
    typedef enum logic [1:0] {
        KIND_HEARTBEAT = 2'd0,
        KIND_FINISH    = 2'd1,
        KIND_CHECKOUT  = 2'd2,
        KIND_TICK      = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        STS_REFRESHED = 3'd0,
        STS_ADDED     = 3'd1,
        STS_FULL      = 3'd2,
        STS_FINISHED  = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_CLAIMED   = 3'd5,
        STS_NONE_IDLE = 3'd6,
        STS_TICKED    = 3'd7
    } t_status;

    // Entry states
    typedef enum logic [1:0] {
        ENT_FREE    = 2'd0,
        ENT_IDLE    = 2'd1,
        ENT_RUNNING = 2'd2
    } t_ent_state;

    // Control sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_EVAL  = 2'd1,
        FSM_APPLY = 2'd2
    } t_fsm;

    // Command broadcast to every cell
    typedef struct packed {
        t_kind              kind;
        logic               apply;
        logic               any_match;
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [AGE_W-1:0]   age_limit;
    } t_cell_cmd;

    // Data handed from one cell to the next
    typedef struct packed {
        logic               taken;
        logic               any_match;
        logic [IDX_W-1:0]   slot;
        logic [ADDR_W-1:0]  addr_hi;
        logic [ADDR_W-1:0]  addr_lo;
        logic [CNT_W-1:0]   expired;
    } t_chain;

    // Registered result
    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  worker_hi;
        logic [ADDR_W-1:0]  worker_lo;
        logic [CNT_W-1:0]   expired;
    } t_result;

endpackage

// ===== rtl/wlt_if.sv =====
// ----------------------------------------------------------------------------
// wlt_if: command and result channels of the worker lease table
// Valid/ready channels; a transfer takes place when valid and ready are high.
// ----------------------------------------------------------------------------
interface wlt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;

    modport source (output valid, output kind, output addr_hi, output addr_lo,
                    input ready);
    modport sink   (input valid, input kind, input addr_hi, input addr_lo,
                    output ready);
endinterface

interface wlt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] slot;
    logic [7:0] worker_hi;
    logic [7:0] worker_lo;
    logic [3:0] expired;

    modport source (output valid, output status, output slot, output worker_hi,
                    output worker_lo, output expired, input ready);
    modport sink   (input valid, input status, input slot, input worker_hi,
                    input worker_lo, input expired, output ready);
endinterface

// ===== rtl/wlt_cell.sv =====
// ----------------------------------------------------------------------------
// wlt_cell: one entry of the worker lease table
// Holds state, age and address of one worker, takes part in the lowest-index
// priority chain and adds its expiry to the running count.
// ----------------------------------------------------------------------------
module wlt_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [wlt_pkg::IDX_W-1:0]         i_idx,
    input  wlt_pkg::t_cell_cmd                i_cmd,
    input  wlt_pkg::t_chain                   i_chain,
    output wlt_pkg::t_chain                   o_chain,
    output logic                              o_grant
);

    wlt_pkg::t_ent_state              r_state;
    logic [wlt_pkg::AGE_W-1:0]        r_age;
    logic [wlt_pkg::ADDR_W-1:0]       r_addr_hi;
    logic [wlt_pkg::ADDR_W-1:0]       r_addr_lo;

    logic live;
    logic match;
    logic sel;
    logic grant;
    logic expire;

    // Local compare against the command
    always_comb begin
        live   = (r_state != wlt_pkg::ENT_FREE);
        match  = live && (r_addr_hi == i_cmd.addr_hi) && (r_addr_lo == i_cmd.addr_lo);
        expire = (i_cmd.kind == wlt_pkg::KIND_TICK) && live && (r_age > i_cmd.age_limit);
        unique case (i_cmd.kind)
            wlt_pkg::KIND_HEARTBEAT: begin
                sel = i_cmd.any_match ? match : (r_state == wlt_pkg::ENT_FREE);
            end
            wlt_pkg::KIND_FINISH: begin
                sel = match;
            end
            wlt_pkg::KIND_CHECKOUT: begin
                sel = (r_state == wlt_pkg::ENT_IDLE);
            end
            default: begin
                sel = 1'b0;
            end
        endcase
        grant = sel && !i_chain.taken;
    end

    // Pass the chain on to the next cell
    always_comb begin
        o_chain.taken     = i_chain.taken | sel;
        o_chain.any_match = i_chain.any_match | match;
        o_chain.slot      = grant ? i_idx : i_chain.slot;
        o_chain.addr_hi   = grant ? r_addr_hi : i_chain.addr_hi;
        o_chain.addr_lo   = grant ? r_addr_lo : i_chain.addr_lo;
        if (expire && (i_chain.expired != wlt_pkg::CNT_MAX)) begin
            o_chain.expired = i_chain.expired + wlt_pkg::CNT_W'(1);
        end else begin
            o_chain.expired = i_chain.expired;
        end
        o_grant = grant;
    end

    // Update the entry when the command is applied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlt_pkg::ENT_FREE;
        end else if (i_cmd.apply) begin
            unique case (i_cmd.kind)
                wlt_pkg::KIND_HEARTBEAT: begin
                    if (grant) begin
                        r_age <= '0;
                        if (!i_cmd.any_match) begin
                            r_state   <= wlt_pkg::ENT_IDLE;
                            r_addr_hi <= i_cmd.addr_hi;
                            r_addr_lo <= i_cmd.addr_lo;
                        end
                    end
                end
                wlt_pkg::KIND_FINISH: begin
                    if (grant) begin
                        r_state <= wlt_pkg::ENT_IDLE;
                        r_age   <= '0;
                    end
                end
                wlt_pkg::KIND_CHECKOUT: begin
                    if (grant) begin
                        r_state <= wlt_pkg::ENT_RUNNING;
                    end
                end
                default: begin
                    if (expire) begin
                        r_state <= wlt_pkg::ENT_FREE;
                    end else if (live && (r_age < wlt_pkg::AGE_MAX)) begin
                        r_age <= r_age + wlt_pkg::AGE_W'(1);
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/worker_lease_table_top.sv =====
// ----------------------------------------------------------------------------
// worker_lease_table_top: worker lease table
// A row of entry cells under a small sequencer that evaluates one command at
// a time and registers one result per command.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  i_in    | in        | kind, addr_hi, addr_lo
//  o_out   | out       | status, slot, worker_hi, worker_lo, expired
//  cfg     | in        | i_cfg_we, i_cfg_wdata (age_limit)
//
//  Each command has an evaluate step to gather the address match over the
//  cell row and an apply step to run the priority chain and update cells.
//  A new command is accepted in the cycle its predecessor is applied.
//  The result register holds one result; a stalled result holds the
//  command in the apply step until the result is taken.
//  Synchronous active-low reset frees all entries and sets age_limit to 6.
// ----------------------------------------------------------------------------
module worker_lease_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wlt_in_if.sink       i_in,
    wlt_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [5:0]   i_cfg_wdata
);

    wlt_pkg::t_fsm                    r_fsm;
    wlt_pkg::t_fsm                    n_fsm;
    wlt_pkg::t_kind                   r_kind;
    logic [wlt_pkg::ADDR_W-1:0]       r_addr_hi;
    logic [wlt_pkg::ADDR_W-1:0]       r_addr_lo;
    logic                             r_any_match;
    logic [wlt_pkg::AGE_W-1:0]        r_age_limit;
    wlt_pkg::t_result                 r_out;
    wlt_pkg::t_result                 n_out;
    logic                             r_out_valid;

    logic                             in_ready;
    logic                             accept;
    logic                             fire;
    wlt_pkg::t_cell_cmd               cmd;
    wlt_pkg::t_chain                  chain [wlt_pkg::ENTRIES+1];
    logic [wlt_pkg::ENTRIES-1:0]      grants;
    logic [wlt_pkg::IDX_W+2:0]        slot_ext;

    // Row of entry cells
    assign chain[0] = '0;

    for (genvar g = 0; g < wlt_pkg::ENTRIES; g++) begin : g_cell
        wlt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (wlt_pkg::IDX_W'(g)),
            .i_cmd   (cmd),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_grant (grants[g])
        );
    end

    // Sequencer outputs
    always_comb begin
        fire     = (r_fsm == wlt_pkg::FSM_APPLY) && (!r_out_valid || o_out.ready);
        in_ready = (r_fsm == wlt_pkg::FSM_IDLE) || fire;
        accept   = i_in.valid && in_ready;
    end

    // Sequencer next state
    always_comb begin
        unique case (r_fsm)
            wlt_pkg::FSM_IDLE: begin
                n_fsm = accept ? wlt_pkg::FSM_EVAL : wlt_pkg::FSM_IDLE;
            end
            wlt_pkg::FSM_EVAL: begin
                n_fsm = wlt_pkg::FSM_APPLY;
            end
            wlt_pkg::FSM_APPLY: begin
                if (fire) begin
                    n_fsm = accept ? wlt_pkg::FSM_EVAL : wlt_pkg::FSM_IDLE;
                end else begin
                    n_fsm = wlt_pkg::FSM_APPLY;
                end
            end
            default: begin
                n_fsm = wlt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= wlt_pkg::FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Command broadcast
    always_comb begin
        cmd.kind      = r_kind;
        cmd.apply     = fire;
        cmd.any_match = r_any_match;
        cmd.addr_hi   = r_addr_hi;
        cmd.addr_lo   = r_addr_lo;
        cmd.age_limit = r_age_limit;
    end

    // Capture the command on transfer, the match summary in the evaluate step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= wlt_pkg::t_kind'(i_in.kind);
            r_addr_hi <= i_in.addr_hi;
            r_addr_lo <= i_in.addr_lo;
        end
        if (r_fsm == wlt_pkg::FSM_EVAL) begin
            r_any_match <= chain[wlt_pkg::ENTRIES].any_match;
        end
    end

    // Age limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= wlt_pkg::AGE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_age_limit <= i_cfg_wdata;
        end
    end

    // Build the result from the chain end
    assign slot_ext = {3'b000, chain[wlt_pkg::ENTRIES].slot};

    always_comb begin
        n_out           = '0;
        n_out.status    = wlt_pkg::STS_TICKED;
        unique case (r_kind)
            wlt_pkg::KIND_HEARTBEAT: begin
                if (chain[wlt_pkg::ENTRIES].taken) begin
                    n_out.status    = r_any_match ? wlt_pkg::STS_REFRESHED
                                                  : wlt_pkg::STS_ADDED;
                    n_out.slot      = slot_ext[2:0];
                    n_out.worker_hi = r_addr_hi;
                    n_out.worker_lo = r_addr_lo;
                end else begin
                    n_out.status = wlt_pkg::STS_FULL;
                end
            end
            wlt_pkg::KIND_FINISH: begin
                if (chain[wlt_pkg::ENTRIES].taken) begin
                    n_out.status    = wlt_pkg::STS_FINISHED;
                    n_out.slot      = slot_ext[2:0];
                    n_out.worker_hi = r_addr_hi;
                    n_out.worker_lo = r_addr_lo;
                end else begin
                    n_out.status = wlt_pkg::STS_NOT_FOUND;
                end
            end
            wlt_pkg::KIND_CHECKOUT: begin
                if (chain[wlt_pkg::ENTRIES].taken) begin
                    n_out.status    = wlt_pkg::STS_CLAIMED;
                    n_out.slot      = slot_ext[2:0];
                    n_out.worker_hi = chain[wlt_pkg::ENTRIES].addr_hi;
                    n_out.worker_lo = chain[wlt_pkg::ENTRIES].addr_lo;
                end else begin
                    n_out.status = wlt_pkg::STS_NONE_IDLE;
                end
            end
            default: begin
                n_out.status  = wlt_pkg::STS_TICKED;
                n_out.expired = chain[wlt_pkg::ENTRIES].expired;
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Drive the channels
    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out.status;
    assign o_out.slot      = r_out.slot;
    assign o_out.worker_hi = r_out.worker_hi;
    assign o_out.worker_lo = r_out.worker_lo;
    assign o_out.expired   = r_out.expired;

`ifndef SYNTHESIS
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> $onehot0(grants))
        else $error("more than one cell granted");

    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_fsm == wlt_pkg::FSM_EVAL))
        else $error("accepted command not evaluated next");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !fire)
        else $error("result register overwritten while stalled");

    a_expired_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.expired != '0)) |->
            (r_out.status == wlt_pkg::STS_TICKED))
        else $error("expired count on a non-tick result");

    a_apply_follows_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == wlt_pkg::FSM_EVAL) |=> (r_fsm == wlt_pkg::FSM_APPLY))
        else $error("evaluate step not followed by apply");
`endif

endmodule
